### rtl/vertex_box_selection_test_core_defines.svh
// assertion macros used by the checker in vbst_checker.sv
`ifndef VERTEX_BOX_SELECTION_TEST_CORE_DEFINES_SVH
`define VERTEX_BOX_SELECTION_TEST_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define VBST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// antecedent implies consequent after the delay given by n
`define VBST_ASSERT_DELAYED(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
		else $error("%m: delayed check failed");

`endif

### rtl/vbst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vbst_pkg;

	// field widths
	localparam int VID_W    = 16;
	localparam int POS_W    = 32;
	localparam int COEF_W   = 16;
	localparam int CORNER_W = 16;

	// default width of the vertex index
	localparam int INDEX_BITS_DEFAULT = 16;

	// arithmetic widths: coefficient times position, row sums, box products
	localparam int PROD_W     = COEF_W + POS_W;
	localparam int CLIP_W     = PROD_W + 2;
	localparam int BOX_PROD_W = CLIP_W + CORNER_W;
	localparam int XY_SHIFT   = 14;

	// configuration port
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// cycles from an accepted transaction to its done strobe
	localparam int LATENCY = 5;

	// register indexes
	typedef enum logic [2:0] {
		REG_ROW0   = 3'd0,
		REG_ROW1   = 3'd1,
		REG_ROW2   = 3'd2,
		REG_ROW3   = 3'd3,
		REG_BOX_ST = 3'd4,
		REG_BOX_EN = 3'd5,
		REG_EXTEND = 3'd6
	} reg_idx_t;

endpackage

`default_nettype wire

### rtl/vertex_box_selection_test_core.sv
// vertex box selection test: one vertex transaction per cycle, busy is never high
// done is registered: it is the last bit of the valid chain started by the edge that accepts start
// the five stages are: 12 coefficient multiplies, two adder levels for the row sums,
// the corner-times-w multiplies with the depth test, and the final box compares
// the receiver cannot stall; results are strobed on done for one cycle
// reset clears the stage valid bits and all configuration registers to zero
`timescale 1ns / 1ps
`default_nettype none

module vertex_box_selection_test_core #(
	parameter int INDEX_BITS = vbst_pkg::INDEX_BITS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [vbst_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [vbst_pkg::DATA_W-1:0]       pwdata,
	output logic      [vbst_pkg::DATA_W-1:0]       prdata,
	output logic                                   pready,
	// command side
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [vbst_pkg::VID_W-1:0]        vertex_id,
	input  wire logic signed [vbst_pkg::POS_W-1:0] pos_x,
	input  wire logic signed [vbst_pkg::POS_W-1:0] pos_y,
	input  wire logic signed [vbst_pkg::POS_W-1:0] pos_z,
	input  wire logic                              was_selected,
	// result side
	output logic                                   done,
	output logic      [vbst_pkg::VID_W-1:0]        result_id,
	output logic                                   in_box,
	output logic                                   highlighted
);

	localparam int ID_W = (INDEX_BITS < vbst_pkg::VID_W) ? INDEX_BITS : vbst_pkg::VID_W;
	localparam int PW   = vbst_pkg::PROD_W;
	localparam int CW   = vbst_pkg::CLIP_W;
	localparam int BW   = vbst_pkg::BOX_PROD_W;
	localparam int KW   = vbst_pkg::CORNER_W;

	// configuration registers
	logic [vbst_pkg::DATA_W-1:0] row0_q, row1_q, row2_q, row3_q;
	logic [31:0]                 box_st_q, box_en_q;
	logic                        extend_q;

	// sorted box corners
	logic signed [KW-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;

	// pipeline state
	logic                 valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [ID_W-1:0]      id_s1, id_s2, id_s3, id_s4, id_s5;
	logic                 sel_s1, sel_s2, sel_s3, sel_s4;
	logic signed [PW-1:0] prod_s1 [4][3];
	logic signed [CW-1:0] sum_a_s2 [4];
	logic signed [CW-1:0] sum_b_s2 [4];
	logic signed [CW-1:0] clip_s3 [4];
	logic                 depth_ok_s4;
	logic signed [BW-1:0] xs_s4, ys_s4;
	logic signed [BW-1:0] lox_w_s4, hix_w_s4, loy_w_s4, hiy_w_s4;
	logic                 in_box_s5, highlighted_s5;

	logic                       wr_en;
	vbst_pkg::reg_idx_t         wr_idx;
	logic [vbst_pkg::DATA_W-1:0] rows [4];
	logic signed [KW-1:0]       st_x, st_y, en_x, en_y;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_idx = vbst_pkg::reg_idx_t'(paddr[vbst_pkg::ADDR_W-1:3]);

	assign rows[0] = row0_q;
	assign rows[1] = row1_q;
	assign rows[2] = row2_q;
	assign rows[3] = row3_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q   <= '0;
			row1_q   <= '0;
			row2_q   <= '0;
			row3_q   <= '0;
			box_st_q <= '0;
			box_en_q <= '0;
			extend_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_idx)
				vbst_pkg::REG_ROW0:   row0_q   <= pwdata;
				vbst_pkg::REG_ROW1:   row1_q   <= pwdata;
				vbst_pkg::REG_ROW2:   row2_q   <= pwdata;
				vbst_pkg::REG_ROW3:   row3_q   <= pwdata;
				vbst_pkg::REG_BOX_ST: box_st_q <= pwdata[31:0];
				vbst_pkg::REG_BOX_EN: box_en_q <= pwdata[31:0];
				vbst_pkg::REG_EXTEND: extend_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (wr_idx)
			vbst_pkg::REG_ROW0:   prdata = row0_q;
			vbst_pkg::REG_ROW1:   prdata = row1_q;
			vbst_pkg::REG_ROW2:   prdata = row2_q;
			vbst_pkg::REG_ROW3:   prdata = row3_q;
			vbst_pkg::REG_BOX_ST: prdata = {32'h0, box_st_q};
			vbst_pkg::REG_BOX_EN: prdata = {32'h0, box_en_q};
			vbst_pkg::REG_EXTEND: prdata = {63'h0, extend_q};
			default:              prdata = '0;
		endcase
	end

	// per-axis min and max of the two corners
	assign st_x = box_st_q[15:0];
	assign st_y = box_st_q[31:16];
	assign en_x = box_en_q[15:0];
	assign en_y = box_en_q[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_x_q <= '0;
			hi_x_q <= '0;
			lo_y_q <= '0;
			hi_y_q <= '0;
		end else begin
			lo_x_q <= (st_x < en_x) ? st_x : en_x;
			hi_x_q <= (st_x < en_x) ? en_x : st_x;
			lo_y_q <= (st_y < en_y) ? st_y : en_y;
			hi_y_q <= (st_y < en_y) ? en_y : st_y;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 1: coefficient times position for the x, y, z columns
	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			prod_s1[r][0] <= $signed(rows[r][15:0]) * pos_x;
			prod_s1[r][1] <= $signed(rows[r][31:16]) * pos_y;
			prod_s1[r][2] <= $signed(rows[r][47:32]) * pos_z;
		end
		id_s1  <= vertex_id[ID_W-1:0];
		sel_s1 <= was_selected;
	end

	// stage 2: pairwise sums, the w column is the coefficient shifted left by 16 bits
	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			sum_a_s2[r] <= CW'(prod_s1[r][0]) + CW'(prod_s1[r][1]);
			sum_b_s2[r] <= CW'(prod_s1[r][2]) + CW'($signed({rows[r][63:48], 16'h0000}));
		end
		id_s2  <= id_s1;
		sel_s2 <= sel_s1;
	end

	// stage 3: clip x, y, depth and w
	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			clip_s3[r] <= sum_a_s2[r] + sum_b_s2[r];
		end
		id_s3  <= id_s2;
		sel_s3 <= sel_s2;
	end

	// stage 4: depth range test and corner times w
	always_ff @(posedge clk) begin
		depth_ok_s4 <= (clip_s3[3] > 0) && (clip_s3[2] >= 0) && (clip_s3[2] <= clip_s3[3]);
		xs_s4       <= BW'(clip_s3[0]) <<< vbst_pkg::XY_SHIFT;
		ys_s4       <= BW'(clip_s3[1]) <<< vbst_pkg::XY_SHIFT;
		lox_w_s4    <= lo_x_q * clip_s3[3];
		hix_w_s4    <= hi_x_q * clip_s3[3];
		loy_w_s4    <= lo_y_q * clip_s3[3];
		hiy_w_s4    <= hi_y_q * clip_s3[3];
		id_s4       <= id_s3;
		sel_s4      <= sel_s3;
	end

	// stage 5: box edges included, then the highlight rule
	logic box_hit;
	assign box_hit = depth_ok_s4 &&
		(xs_s4 >= lox_w_s4) && (xs_s4 <= hix_w_s4) &&
		(ys_s4 >= loy_w_s4) && (ys_s4 <= hiy_w_s4);

	always_ff @(posedge clk) begin
		in_box_s5      <= box_hit;
		highlighted_s5 <= box_hit || (extend_q && sel_s4);
		id_s5          <= id_s4;
	end

	// result ports
	assign done        = valid_s5;
	assign result_id   = vbst_pkg::VID_W'(id_s5);
	assign in_box      = in_box_s5;
	assign highlighted = highlighted_s5;

endmodule

`default_nettype wire

### rtl/vbst_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "vertex_box_selection_test_core_defines.svh"

module vbst_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic                       busy,
	input wire logic [vbst_pkg::VID_W-1:0] vertex_id,
	input wire logic                       was_selected,
	input wire logic                       done,
	input wire logic [vbst_pkg::VID_W-1:0] result_id,
	input wire logic                       in_box,
	input wire logic                       highlighted
);

	// every accepted transaction gives a done strobe after the fixed latency
	`VBST_ASSERT_DELAYED(a_done_follows, clk, arst_n, start && !busy, vbst_pkg::LATENCY, done)

	// no done strobe without a transaction accepted the latency before
	`VBST_ASSERT_IMPL(a_no_spurious_done, clk, arst_n, done, $past(start && !busy, vbst_pkg::LATENCY))

	// the low index bits come back with their own transaction
	`VBST_ASSERT_IMPL(a_id_order, clk, arst_n, done, result_id[7:0] == $past(vertex_id[7:0], vbst_pkg::LATENCY))

	// a vertex in the box is always highlighted
	`VBST_ASSERT_IMPL(a_box_highlights, clk, arst_n, done && in_box, highlighted)

	// an unselected vertex is highlighted only when it lies in the box
	`VBST_ASSERT_IMPL(a_unselected_match, clk, arst_n, done && !$past(was_selected, vbst_pkg::LATENCY), highlighted == in_box)

endmodule

bind vertex_box_selection_test_core vbst_checker u_vbst_checker (.*);

`default_nettype wire
